### src/qu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the quick-union disjoint-set engine.
package qu_pkg;

	// Element indices arrive as 8-bit words, so no more than 256 entries are reachable.
	localparam int IDX_W     = 8;
	localparam int MAX_DEPTH = 256;
	// Width that holds any legal element count, 65536 included.
	localparam int LIM_W     = 17;

	localparam logic KIND_UNION = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		idx_t wr_data;
	} qu_mem_req_t;

endpackage

### src/quick_union_disjoint_set.sv
`timescale 1ns / 1ps
// Top level of the quick-union disjoint-set engine.
//
//   channel  handshake             word
//   command  start high, busy low  kind, first_element, second_element
//   result   done (one cycle)      are_connected
//
// A query walks the parent links from first_element up to its root and then from
// second_element up to its root; each link costs one read of the parent table.
// A union takes the same walk and ends with one write. A query with an index out
// of range is answered with zero in the following cycle; a union with one is dropped.
// After reset the table is swept once over min(ENTRIES, 256) entries, with busy held high.
// The receiver cannot stall: done lasts exactly one cycle.
module quick_union_disjoint_set import qu_pkg::*; #(
	parameter int ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       kind,
	input  logic [7:0] first_element,
	input  logic [7:0] second_element,
	output logic       done,
	output logic       are_connected
);

	localparam int DEPTH = (ENTRIES < MAX_DEPTH) ? ENTRIES : MAX_DEPTH;

	qu_mem_req_t req;
	idx_t        rd_data;

	qu_ctrl #(
		.ENTRIES(ENTRIES),
		.DEPTH  (DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.first_element (first_element),
		.second_element(second_element),
		.rd_data       (rd_data),
		.req           (req),
		.busy          (busy),
		.done          (done),
		.are_connected (are_connected)
	);

	qu_parent_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.req    (req),
		.rd_data(rd_data)
	);

endmodule

### src/qu_parent_ram.sv
`timescale 1ns / 1ps
// Parent table: one-port-read, one-port-write synchronous memory with a registered read.
module qu_parent_ram import qu_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  qu_mem_req_t req,
	output idx_t        rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data[AW-1:0];
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = IDX_W'(rd_q);

endmodule

### src/qu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: clears the table after reset, walks parent links and applies unions.
module qu_ctrl import qu_pkg::*; #(
	parameter int ENTRIES = 256,
	parameter int DEPTH   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        kind,
	input  idx_t        first_element,
	input  idx_t        second_element,
	input  idx_t        rd_data,
	output qu_mem_req_t req,
	output logic        busy,
	output logic        done,
	output logic        are_connected
);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_FIND_A = 4'b0100,
		ST_FIND_B = 4'b1000
	} state_t;

	state_t state_q;
	idx_t   node_q;
	idx_t   root_a_q;
	idx_t   b_q;
	idx_t   clr_q;
	logic   kind_q;
	logic   done_q;
	logic   conn_q;
	logic   in_range;
	logic   at_root;

	assign in_range = ({(LIM_W-IDX_W)'(0), first_element} < LIM_W'(ENTRIES)) &&
		({(LIM_W-IDX_W)'(0), second_element} < LIM_W'(ENTRIES));

	// The registered read word belongs to node_q; a self link marks the root.
	assign at_root = (rd_data == node_q);

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_CLEAR: begin
				req.wr_en   = 1'b1;
				req.wr_addr = clr_q;
				req.wr_data = clr_q;
			end
			ST_IDLE: begin
				if (start && in_range) begin
					req.rd_en   = 1'b1;
					req.rd_addr = first_element;
				end
			end
			ST_FIND_A: begin
				req.rd_en   = 1'b1;
				req.rd_addr = at_root ? b_q : rd_data;
			end
			ST_FIND_B: begin
				if (at_root) begin
					req.wr_en   = (kind_q == KIND_UNION);
					req.wr_addr = root_a_q;
					req.wr_data = node_q;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = rd_data;
				end
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			conn_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(DEPTH-1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						kind_q <= kind;
						b_q    <= second_element;
						node_q <= first_element;
						if (in_range) begin
							state_q <= ST_FIND_A;
						end else if (kind == KIND_QUERY) begin
							done_q <= 1'b1;
							conn_q <= 1'b0;
						end
					end
				end
				ST_FIND_A: begin
					if (at_root) begin
						root_a_q <= node_q;
						node_q   <= b_q;
						state_q  <= ST_FIND_B;
					end else begin
						node_q <= rd_data;
					end
				end
				ST_FIND_B: begin
					if (at_root) begin
						state_q <= ST_IDLE;
						if (kind_q == KIND_QUERY) begin
							done_q <= 1'b1;
							conn_q <= (root_a_q == node_q);
						end
					end else begin
						node_q <= rd_data;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign are_connected = conn_q;

endmodule

### src/qu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quick-union engine and its bind to the top level.
module qu_checker import qu_pkg::*; #(
	parameter int ENTRIES = 256
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       kind,
	input logic [7:0] first_element,
	input logic [7:0] second_element,
	input logic       done,
	input logic       are_connected
);

	logic accept;
	logic out_of_range;

	assign accept = start && !busy;
	assign out_of_range =
		({(LIM_W-IDX_W)'(0), first_element} >= LIM_W'(ENTRIES)) ||
		({(LIM_W-IDX_W)'(0), second_element} >= LIM_W'(ENTRIES));

	// A result is shown only once its word is finished and the engine is free.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// A result always follows an accepted word or a walk in progress.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) || $past(busy)))
		else $error("done without a word in flight");

	// A union never produces a result in the following cycle.
	a_union_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_UNION) |=> !done)
		else $error("union produced a result");

	// A query with an index beyond the table is answered at once with zero.
	a_range_query: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_QUERY && out_of_range) |=> (done && !are_connected))
		else $error("out-of-range query not answered with zero");

endmodule

bind quick_union_disjoint_set qu_checker #(
	.ENTRIES(ENTRIES)
) u_qu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.first_element (first_element),
	.second_element(second_element),
	.done          (done),
	.are_connected (are_connected)
);
